[rtl/core/mtep_pkg.sv]
`default_nettype none

package mtep_pkg;

   // Longest variable-length quantity, in bytes.
   localparam logic [2:0] MAX_QUANTITY_BYTES = 3'd4;

   localparam logic [7:0] STATUS_FLAG  = 8'h80;
   localparam logic [7:0] STATUS_SYS   = 8'hF0;
   localparam logic [7:0] STATUS_SYSEX = 8'hF0;
   localparam logic [7:0] STATUS_ESC   = 8'hF7;
   localparam logic [7:0] STATUS_META  = 8'hFF;
   localparam logic [7:0] META_EOT     = 8'h2F;
   localparam logic [3:0] CHAN_PROG    = 4'hC;
   localparam logic [3:0] CHAN_PRESS   = 4'hD;

   typedef enum logic [2:0] {
      PH_DELTA   = 3'd0,
      PH_STATUS  = 3'd1,
      PH_DATA1   = 3'd2,
      PH_DATA2   = 3'd3,
      PH_MTYPE   = 3'd4,
      PH_LENGTH  = 3'd5,
      PH_PAYLOAD = 3'd6
   } phase_type;

   typedef enum logic [2:0] {
      ROLE_DELTA   = 3'd0,
      ROLE_STATUS  = 3'd1,
      ROLE_DATA    = 3'd2,
      ROLE_MTYPE   = 3'd3,
      ROLE_LENGTH  = 3'd4,
      ROLE_PAYLOAD = 3'd5
   } role_type;

   typedef enum logic [2:0] {
      ERR_NONE       = 3'd0,
      ERR_NO_RUNNING = 3'd1,
      ERR_QUANTITY   = 3'd2,
      ERR_UNDEFINED  = 3'd3,
      ERR_AFTER_END  = 3'd4
   } error_type;

   typedef struct packed {
      phase_type   phase;
      logic [7:0]  live_status;
      logic [7:0]  current_status;
      logic [27:0] delta_accum;
      logic [2:0]  quantity_bytes;
      logic [27:0] remaining_bytes;
      logic [27:0] length_reg;
      logic [7:0]  meta_type_reg;
      logic        ended;
   } state_type;

   typedef struct packed {
      role_type    byte_role;
      logic [7:0]  byte_value;
      logic [7:0]  event_status;
      logic [27:0] delta_time;
      logic [27:0] payload_length;
      logic [7:0]  meta_kind;
      logic        event_last;
      logic        track_end;
      error_type   error_code;
   } result_type;

   localparam state_type STATE_RESET = '{
      phase:           PH_DELTA,
      live_status:     8'h00,
      current_status:  8'h00,
      delta_accum:     28'd0,
      quantity_bytes:  3'd0,
      remaining_bytes: 28'd0,
      length_reg:      28'd0,
      meta_type_reg:   8'h00,
      ended:           1'b0
   };

endpackage

`default_nettype wire

[rtl/core/mtep_step.sv]
`default_nettype none

// Next-state and result logic for one track byte.
module mtep_step (
   input  mtep_pkg::state_type  state_cur,
   input  logic [7:0]           data_byte,
   input  logic                 track_start,
   output mtep_pkg::state_type  state_nxt,
   output mtep_pkg::result_type result
);

   mtep_pkg::state_type s;
   mtep_pkg::state_type n;
   mtep_pkg::role_type  role;
   mtep_pkg::error_type err;
   logic                last;
   logic                tend;
   logic [2:0]          qb_inc;
   logic                vlq_over;
   logic                vlq_done;
   logic [27:0]         delta_base;
   logic [27:0]         len_new;
   logic [27:0]         rem_dec;
   logic                one_data;
   logic                one_data_run;

   always_comb begin
      s = track_start ? mtep_pkg::STATE_RESET : state_cur;
      n = s;
      role = mtep_pkg::ROLE_DELTA;
      err = mtep_pkg::ERR_NONE;
      last = 1'b0;
      tend = 1'b0;

      qb_inc = s.quantity_bytes + 3'd1;
      vlq_over = data_byte[7] && (qb_inc >= mtep_pkg::MAX_QUANTITY_BYTES);
      vlq_done = !data_byte[7] || vlq_over;
      delta_base = (s.quantity_bytes == 3'd0) ? 28'd0 : s.delta_accum;
      len_new = {s.length_reg[20:0], data_byte[6:0]};
      rem_dec = s.remaining_bytes - 28'd1;
      one_data = (s.current_status[7:4] == mtep_pkg::CHAN_PROG)
              || (s.current_status[7:4] == mtep_pkg::CHAN_PRESS);
      one_data_run = (s.live_status[7:4] == mtep_pkg::CHAN_PROG)
                  || (s.live_status[7:4] == mtep_pkg::CHAN_PRESS);

      if (s.ended) begin
         role = mtep_pkg::ROLE_PAYLOAD;
         err = mtep_pkg::ERR_AFTER_END;
      end else begin
         case (s.phase)
            mtep_pkg::PH_DELTA: begin
               role = mtep_pkg::ROLE_DELTA;
               if (s.quantity_bytes == 3'd0) begin
                  n.current_status = 8'h00;
                  n.length_reg = 28'd0;
                  n.meta_type_reg = 8'h00;
               end
               n.delta_accum = {delta_base[20:0], data_byte[6:0]};
               n.quantity_bytes = vlq_done ? 3'd0 : qb_inc;
               if (vlq_over) err = mtep_pkg::ERR_QUANTITY;
               if (vlq_done) n.phase = mtep_pkg::PH_STATUS;
            end
            mtep_pkg::PH_STATUS: begin
               if (data_byte < mtep_pkg::STATUS_FLAG) begin
                  role = mtep_pkg::ROLE_DATA;
                  if (s.live_status == 8'h00) begin
                     n.current_status = 8'h00;
                     err = mtep_pkg::ERR_NO_RUNNING;
                     last = 1'b1;
                     n.phase = mtep_pkg::PH_DELTA;
                  end else begin
                     n.current_status = s.live_status;
                     if (one_data_run) begin
                        last = 1'b1;
                        n.phase = mtep_pkg::PH_DELTA;
                     end else begin
                        n.phase = mtep_pkg::PH_DATA2;
                     end
                  end
               end else begin
                  role = mtep_pkg::ROLE_STATUS;
                  n.current_status = data_byte;
                  if (data_byte < mtep_pkg::STATUS_SYS) begin
                     n.live_status = data_byte;
                     n.phase = mtep_pkg::PH_DATA1;
                  end else if (data_byte == mtep_pkg::STATUS_META) begin
                     n.live_status = 8'h00;
                     n.phase = mtep_pkg::PH_MTYPE;
                  end else if (data_byte == mtep_pkg::STATUS_SYSEX
                            || data_byte == mtep_pkg::STATUS_ESC) begin
                     n.live_status = 8'h00;
                     n.quantity_bytes = 3'd0;
                     n.length_reg = 28'd0;
                     n.phase = mtep_pkg::PH_LENGTH;
                  end else begin
                     n.live_status = 8'h00;
                     err = mtep_pkg::ERR_UNDEFINED;
                     last = 1'b1;
                     n.phase = mtep_pkg::PH_DELTA;
                  end
               end
            end
            mtep_pkg::PH_DATA1: begin
               role = mtep_pkg::ROLE_DATA;
               if (one_data) begin
                  last = 1'b1;
                  n.phase = mtep_pkg::PH_DELTA;
               end else begin
                  n.phase = mtep_pkg::PH_DATA2;
               end
            end
            mtep_pkg::PH_DATA2: begin
               role = mtep_pkg::ROLE_DATA;
               last = 1'b1;
               n.phase = mtep_pkg::PH_DELTA;
            end
            mtep_pkg::PH_MTYPE: begin
               role = mtep_pkg::ROLE_MTYPE;
               n.meta_type_reg = data_byte;
               n.quantity_bytes = 3'd0;
               n.length_reg = 28'd0;
               n.phase = mtep_pkg::PH_LENGTH;
            end
            mtep_pkg::PH_LENGTH: begin
               role = mtep_pkg::ROLE_LENGTH;
               n.length_reg = len_new;
               n.quantity_bytes = vlq_done ? 3'd0 : qb_inc;
               if (vlq_over) err = mtep_pkg::ERR_QUANTITY;
               if (vlq_done) begin
                  n.remaining_bytes = len_new;
                  if (len_new == 28'd0) begin
                     last = 1'b1;
                     n.phase = mtep_pkg::PH_DELTA;
                  end else begin
                     n.phase = mtep_pkg::PH_PAYLOAD;
                  end
               end
            end
            default: begin
               // payload skip
               role = mtep_pkg::ROLE_PAYLOAD;
               n.remaining_bytes = rem_dec;
               if (rem_dec == 28'd0) begin
                  last = 1'b1;
                  n.phase = mtep_pkg::PH_DELTA;
               end
            end
         endcase

         // end-of-track meta completes
         if (last && s.phase != mtep_pkg::PH_STATUS && s.phase != mtep_pkg::PH_DATA1
             && s.phase != mtep_pkg::PH_DATA2
             && n.current_status == mtep_pkg::STATUS_META
             && n.meta_type_reg == mtep_pkg::META_EOT) begin
            tend = 1'b1;
            n.ended = 1'b1;
         end
      end
   end

   always_comb begin
      state_nxt = n;
      result.byte_role = role;
      result.byte_value = data_byte;
      result.event_status = n.current_status;
      result.delta_time = n.delta_accum;
      result.payload_length = n.length_reg;
      result.meta_kind = (n.current_status == mtep_pkg::STATUS_META) ? n.meta_type_reg : 8'h00;
      result.event_last = last;
      result.track_end = tend;
      result.error_code = err;
   end

endmodule

`default_nettype wire

[rtl/core/midi_track_event_parser.sv]
`default_nettype none

// Standard MIDI file track parser. Feed the track chunk data one byte per
// req transaction, with req_track_start high on the first byte of a track
// (it resets the parser before that byte is taken). Every byte produces
// exactly one rsp transaction that tags its role (delta, status, data, meta
// type, length, payload), echoes it, and reports the running event context:
// resolved status (running status applied), accumulated delta time, meta or
// sysex length, meta type, event completion, end of track and an error code.
// Meta and sysex payloads are skipped byte by byte; bytes after end-of-track
// are flagged until the next track start. Throughput is one byte per clock:
// the parser state update is a loop from the state register through the step
// logic, and each result sits in one output register, so a byte is accepted
// whenever the output register is empty or being drained in the same cycle.
// rsp_valid rises in the cycle after req acceptance.
module midi_track_event_parser (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_track_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_byte_role,
   output logic [7:0]  rsp_byte_value,
   output logic [7:0]  rsp_event_status,
   output logic [27:0] rsp_delta_time,
   output logic [27:0] rsp_payload_length,
   output logic [7:0]  rsp_meta_kind,
   output logic        rsp_event_last,
   output logic        rsp_track_end,
   output logic [2:0]  rsp_error_code
);

   mtep_pkg::state_type  state_ff;
   mtep_pkg::state_type  state_in;
   mtep_pkg::result_type rsp_ff;
   mtep_pkg::result_type rsp_in;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   logic                 req_take;

   // Output register is free when empty or handed off this cycle.
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_take  = req_valid && req_ready;

   mtep_step u_step (
      .state_cur   (state_ff),
      .data_byte   (req_data_byte),
      .track_start (req_track_start),
      .state_nxt   (state_in),
      .result      (rsp_in)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Parser state advances only on accepted transactions.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mtep_pkg::STATE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            state_ff <= state_in;
         end
      end
   end

   // Result payload, no reset needed.
   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_byte_role      = rsp_ff.byte_role;
   assign rsp_byte_value     = rsp_ff.byte_value;
   assign rsp_event_status   = rsp_ff.event_status;
   assign rsp_delta_time     = rsp_ff.delta_time;
   assign rsp_payload_length = rsp_ff.payload_length;
   assign rsp_meta_kind      = rsp_ff.meta_kind;
   assign rsp_event_last     = rsp_ff.event_last;
   assign rsp_track_end      = rsp_ff.track_end;
   assign rsp_error_code     = rsp_ff.error_code;

`ifndef SYNTHESIS
   // End of track is always the last byte of an event.
   a_tend_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_ff.track_end || rsp_ff.event_last))
      else $error("track_end without event_last");

   // Once ended, every byte without a track start is flagged.
   a_after_end: assert property (@(posedge clock) disable iff (reset)
      (req_take && state_ff.ended && !req_track_start) |=>
         (rsp_ff.error_code == mtep_pkg::ERR_AFTER_END))
      else $error("byte after end not flagged");

   // Quantity byte counter never reaches the limit.
   a_qb_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.quantity_bytes < mtep_pkg::MAX_QUANTITY_BYTES)
      else $error("quantity byte count out of range");

   // An accepted byte always yields a pending result.
   a_take_valid: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted byte produced no result");
`endif

endmodule

`default_nettype wire
